>>> rtl/udp_flow_table_assert.svh
// ----------------------------------------------------------------------------
// UDP flow table assertion macros
// Concurrent check helpers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UDP_FLOW_TABLE_ASSERT_SVH
`define UDP_FLOW_TABLE_ASSERT_SVH

// check cons in the same cycle as ante
`define UFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("udp_flow_table: same-cycle check failed");

// check cons in the cycle after ante
`define UFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("udp_flow_table: next-cycle check failed");

`endif

>>> rtl/uft_pkg.sv
// ----------------------------------------------------------------------------
// UDP flow table package
// Sizes, controller states and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package uft_pkg;

  localparam int FLOW_SLOTS = 64;
  localparam int IDX_W      = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CNT_W      = $clog2(FLOW_SLOTS + 1);
  localparam int PORT_W     = 16;
  localparam int IP_W       = 32;
  localparam int KEY_W      = 2 * PORT_W + IP_W;
  localparam int SLOT_W     = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN
  } uft_state_e;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_NEW,
    RES_DROP
  } uft_res_e;

  typedef struct packed {
    logic     load;
    logic     scan;
    logic     finish;
    uft_res_e kind;
  } uft_cmd_t;

  typedef struct packed {
    logic             hit;
    logic             exhausted;
    logic             full;
    logic [CNT_W-1:0] fill;
  } uft_sts_t;

endpackage

>>> rtl/uft_ctrl.sv
// ----------------------------------------------------------------------------
// UDP flow table controller
// Sequences capture, slot scan and result hand-off; owns the result valid.
// ----------------------------------------------------------------------------
module uft_ctrl import uft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  uft_sts_t sts_i,
  output uft_cmd_t cmd_o
);

  uft_state_e state_q, state_d;
  logic       out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    cmd_o      = '0;
    cmd_o.kind = RES_HIT;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.exhausted) begin
          if (!out_vld_q || out_ready_i) begin
            cmd_o.finish = 1'b1;
            if (sts_i.hit) begin
              cmd_o.kind = RES_HIT;
            end else if (sts_i.full) begin
              cmd_o.kind = RES_DROP;
            end else begin
              cmd_o.kind = RES_NEW;
            end
            out_vld_d = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

>>> rtl/uft_dpath.sv
// ----------------------------------------------------------------------------
// UDP flow table datapath
// Slot memory with registered read, key compare, fill count and result
// register.
// ----------------------------------------------------------------------------
module uft_dpath import uft_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uft_cmd_t          cmd_i,
  output uft_sts_t          sts_o,
  input  logic [KEY_W-1:0]  key_i,
  input  logic              dns_i,
  output logic              fwd_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              slot_dns_o,
  output logic              created_o
);

  logic [KEY_W:0]      mem [FLOW_SLOTS];
  logic [KEY_W-1:0]    key_q;
  logic                dns_q;
  logic [KEY_W:0]      rd_data_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                cmp_vld_q;
  logic [CNT_W-1:0]    rd_idx_q;
  logic [CNT_W-1:0]    fill_q;
  logic                rd_more;
  logic                append;
  logic                fwd_q, slot_dns_q, created_q;
  logic [SLOT_W-1:0]   slot_q;

  assign rd_more = rd_idx_q < fill_q;
  assign append  = cmd_i.finish && (cmd_i.kind == RES_NEW);

  always_ff @(posedge clk_i) begin
    if (append) begin
      mem[fill_q[IDX_W-1:0]] <= {dns_q, key_q};
    end
    if (cmd_i.scan && rd_more) begin
      rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= rd_more;
        if (rd_more) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      if (append) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      dns_q <= dns_i;
    end
    if (cmd_i.finish) begin
      case (cmd_i.kind)
        RES_HIT: begin
          fwd_q      <= 1'b1;
          slot_q     <= SLOT_W'(cmp_idx_q);
          slot_dns_q <= rd_data_q[KEY_W];
          created_q  <= 1'b0;
        end
        RES_NEW: begin
          fwd_q      <= 1'b1;
          slot_q     <= SLOT_W'(fill_q);
          slot_dns_q <= dns_q;
          created_q  <= 1'b1;
        end
        default: begin
          fwd_q      <= 1'b0;
          slot_q     <= '0;
          slot_dns_q <= 1'b0;
          created_q  <= 1'b0;
        end
      endcase
    end
  end

  assign sts_o.hit       = cmp_vld_q && (rd_data_q[KEY_W-1:0] == key_q);
  assign sts_o.exhausted = !cmp_vld_q && !rd_more;
  assign sts_o.full      = (fill_q == CNT_W'(FLOW_SLOTS));
  assign sts_o.fill      = fill_q;

  assign fwd_o      = fwd_q;
  assign slot_o     = slot_q;
  assign slot_dns_o = slot_dns_q;
  assign created_o  = created_q;

endmodule

>>> rtl/udp_flow_table.sv
// ----------------------------------------------------------------------------
// UDP flow table
// Exact-match flow lookup with in-order slot allocation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one datagram key per transaction: tdata holds
//   guest port, remote IP and remote port; tuser holds the DNS flag.
//   Master channel returns one result per key: tdata holds the slot index,
//   tuser holds forwarded, slot DNS flag and created.
//   Lookup walks the filled slots one per cycle through the slot memory's
//   single registered read port. A hit returns as soon as its slot has been
//   compared; a miss returns once every filled slot has been compared (with
//   no compare at all on an empty table), so a miss on a full table of 64
//   slots walks all of them before its result is loaded.
//   One key is in flight at a time; s_axis_tready is high only when no
//   lookup is running.
//   Reset empties the table at once (fill count to zero) with no sweep.
//   A stalled master side holds the result register; the next key is still
//   taken and scanned, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
`include "udp_flow_table_assert.svh"

module udp_flow_table import uft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // guest_port[15:0], remote_ip[47:16], remote_port[63:48]
  input  logic [0:0]  s_axis_tuser,  // is_dns[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // slot[5:0], zero[7:6]
  output logic [2:0]  m_axis_tuser   // forwarded[0], slot_dns[1], created[2]
);

  uft_cmd_t          cmd;
  uft_sts_t          sts;
  logic              fwd, slot_dns, created;
  logic [SLOT_W-1:0] slot;

  uft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  uft_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .key_i      (s_axis_tdata),
    .dns_i      (s_axis_tuser[0]),
    .fwd_o      (fwd),
    .slot_o     (slot),
    .slot_dns_o (slot_dns),
    .created_o  (created)
  );

  assign m_axis_tdata = {2'b00, slot};
  assign m_axis_tuser = {created, slot_dns, fwd};

  `UFT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `UFT_ASSERT_NEXT(a_fill_on_append, cmd.finish && (cmd.kind == RES_NEW),
                   sts.fill == CNT_W'($past(sts.fill) + 1'b1))
  `UFT_ASSERT_NOW(a_drop_only_full, m_axis_tvalid && !m_axis_tuser[0], sts.full)

endmodule
